>>> src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int RAW_W        = 32;
    localparam int COUNT_OUT_W  = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

    // action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // input beat
    typedef struct packed {
        logic             action;
        logic [RAW_W-1:0] sample_value;
    } t_in;

    // output beat
    typedef struct packed {
        logic [SAMPLE_W-1:0]    median_value;
        logic [COUNT_OUT_W-1:0] valid_count;
    } t_out;

    // one slot of the sorted chain
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] val;
    } t_slot;

endpackage

>>> src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted chain. Holds a sample and its age, and on every
// update takes its value from itself, a neighbor or the new sample so that
// the chain stays sorted after the oldest entry is dropped; a clear empties it.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_clear,
    input  logic                i_full,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_del_le,
    input  logic                i_del_le_prev,
    input  logic                i_le_prev,
    input  t_slot               i_left_slot,
    input  logic [AW-1:0]       i_left_age,
    input  t_slot               i_right_slot,
    input  logic [AW-1:0]       i_right_age,
    output t_slot               o_slot,
    output logic [AW-1:0]       o_age,
    output logic                o_del,
    output logic                o_le
);

    localparam logic [AW-1:0] OLDEST = AW'(DEPTH - 1);

    logic          r_valid;
    logic          n_valid;
    logic [15:0]   r_val;
    logic [15:0]   n_val;
    logic [AW-1:0] r_age;
    logic [AW-1:0] n_age;

    t_slot         self_slot;
    t_slot         rk_slot;
    logic [AW-1:0] rk_age;
    t_slot         rkm1_slot;
    logic [AW-1:0] rkm1_age;

    assign self_slot = '{valid: r_valid, val: r_val};

    // this cell is the oldest entry and leaves on the next add
    assign o_del = r_valid && i_full && (r_age == OLDEST);

    // chain with the oldest entry removed: element k and element k-1
    always_comb begin
        if (i_del_le) begin
            rk_slot = i_right_slot;
            rk_age  = i_right_age;
        end else begin
            rk_slot = self_slot;
            rk_age  = r_age;
        end
        if (i_del_le_prev) begin
            rkm1_slot = self_slot;
            rkm1_age  = r_age;
        end else begin
            rkm1_slot = i_left_slot;
            rkm1_age  = i_left_age;
        end
    end

    assign o_le = rk_slot.valid && (rk_slot.val <= i_sample);

    // pick the next content: remaining element, new sample, or shifted element
    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        n_age   = r_age;
        if (i_load) begin
            if (i_clear) begin
                n_valid = 1'b0;
            end else if (o_le) begin
                n_valid = rk_slot.valid;
                n_val   = rk_slot.val;
                n_age   = AW'(rk_age + 1'b1);
            end else if (i_le_prev) begin
                n_valid = 1'b1;
                n_val   = i_sample;
                n_age   = '0;
            end else begin
                n_valid = rkm1_slot.valid;
                n_val   = rkm1_slot.val;
                n_age   = AW'(rkm1_age + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

    assign o_slot = self_slot;
    assign o_age  = r_age;

endmodule

>>> src/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Median of the last WINDOW_DEPTH samples, kept in a sorted chain of cells.
// ----------------------------------------------------------------------------
//  channel  | signals                              | beat
//  ---------+--------------------------------------+--------------------------
//  input    | i_in_valid, o_in_ready, i_in_data    | add sample or clear
//  output   | o_out_valid, i_out_ready, o_out_data | median and sample count
//
//  For each item, the chain updates at acceptance, and the median is
//  selected from the chain and registered in the next cycle.
//  A new item is taken while the previous result waits, as long as that
//  result leaves the output register in the same cycle.
//  Synchronous active-low reset empties the window; the output stalls freely.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int D     = WINDOW_DEPTH;
    localparam int AW    = (D > 1) ? $clog2(D) : 1;
    localparam int IW    = (D > 1) ? $clog2(D) : 1;
    localparam int CNT_W = $clog2(D + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(D);

    localparam t_slot EMPTY_SLOT = '{valid: 1'b0, val: '0};

    logic                accept;
    logic [SAMPLE_W-1:0] sample_sat;
    logic                full;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_pend;
    logic             r_out_valid;
    t_out             r_out;

    t_slot         slot [D];
    logic [AW-1:0] age  [D];
    logic [D-1:0]  del_mask;
    logic [D-1:0]  le;

    logic [IW-1:0]       med_idx;
    logic [SAMPLE_W-1:0] med_val;

    assign o_in_ready = !r_pend && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // saturate the raw sample to 16 bits
    assign sample_sat = (|i_in_data.sample_value[RAW_W-1:SAMPLE_W]) ? SAMPLE_MAX
                      : i_in_data.sample_value[SAMPLE_W-1:0];

    assign full = (r_cnt == CNT_FULL);

    // sorted chain
    for (genvar k = 0; k < D; k++) begin : g_cell
        logic          del_le;
        logic          del_le_prev;
        logic          le_prev;
        t_slot         left_slot;
        logic [AW-1:0] left_age;
        t_slot         right_slot;
        logic [AW-1:0] right_age;

        assign del_le = |del_mask[k:0];

        if (k == 0) begin : g_first
            assign del_le_prev = 1'b0;
            assign le_prev     = 1'b1;
            assign left_slot   = EMPTY_SLOT;
            assign left_age    = '0;
        end else begin : g_inner
            assign del_le_prev = |del_mask[k-1:0];
            assign le_prev     = le[k-1];
            assign left_slot   = slot[k-1];
            assign left_age    = age[k-1];
        end

        if (k == D - 1) begin : g_last
            assign right_slot = EMPTY_SLOT;
            assign right_age  = '0;
        end else begin : g_mid
            assign right_slot = slot[k+1];
            assign right_age  = age[k+1];
        end

        swm_cell #(
            .DEPTH (D),
            .AW    (AW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (accept),
            .i_clear       (i_in_data.action == ACT_CLEAR),
            .i_full        (full),
            .i_sample      (sample_sat),
            .i_del_le      (del_le),
            .i_del_le_prev (del_le_prev),
            .i_le_prev     (le_prev),
            .i_left_slot   (left_slot),
            .i_left_age    (left_age),
            .i_right_slot  (right_slot),
            .i_right_age   (right_age),
            .o_slot        (slot[k]),
            .o_age         (age[k]),
            .o_del         (del_mask[k]),
            .o_le          (le[k])
        );
    end

    // fill count
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_in_data.action == ACT_CLEAR) begin
                n_cnt = '0;
            end else if (!full) begin
                n_cnt = CNT_W'(r_cnt + 1'b1);
            end
        end
    end

    // median: slot at index count/2; an empty window has no valid slot
    assign med_idx = IW'(r_cnt >> 1);

    always_comb begin
        med_val = '0;
        for (int k = 0; k < D; k++) begin
            if ((IW'(k) == med_idx) && slot[k].valid) begin
                med_val = slot[k].val;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_pend <= accept;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out.median_value <= med_val;
            r_out.valid_count  <= COUNT_OUT_W'(r_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding window median filter, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one item in flight: no second beat in the cycle after a beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("input taken while previous item still in progress");

    // every beat yields a result once the median has been registered
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> ##1 o_out_valid)
        else $error("result missing after input beat");

    // a clear reports an empty window
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.action == ACT_CLEAR) |=> ##1
            (o_out_data.valid_count == '0) && (o_out_data.median_value == '0))
        else $error("clear did not report an empty window");

    // an add always leaves at least one sample (checked for depths below 16)
    a_add_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.action == ACT_ADD) && (WINDOW_DEPTH < 16) |=> ##1
            (o_out_data.valid_count != '0))
        else $error("add reported an empty window");

endmodule

bind sliding_window_median swm_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
